// File: sv/pks_pkg.sv
// shared constants, codes and command/status types of the positional kernel smoother
package pks_pkg;

  localparam int MAX_TAPS_DEF     = 33;
  localparam int WINDOW_DEPTH_DEF = 32;

  localparam int DENS_W = 37;
  localparam int HW     = 6;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNSORTED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] RD_HEAD  = 2'd0;
  localparam logic [1:0] RD_BASE  = 2'd1;
  localparam logic [1:0] RD_ISSUE = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       tap_wr;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       set_first;
    logic       drop;
    logic       head_inc;
    logic       evict_rec;
    logic       insert;
    logic       clear;
    logic       ld_pd;
    logic       iss;
    logic       res_load;
    logic       res_unsorted;
    logic       forced;
    logic       finish;
  } pks_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       head_lt;
    logic       head_cond;
    logic       drop_cond;
    logic       full;
    logic       head_zero;
    logic       unsorted;
    logic       issue_done;
    logic       pipe_empty;
    logic       out_free;
    logic       hold_v;
  } pks_sts_t;

endpackage

// File: sv/pks_datapath.sv
// window memory, kernel memory, multiply-accumulate pipeline and output registers
module pks_datapath #(
  parameter int MAX_TAPS     = pks_pkg::MAX_TAPS_DEF,
  parameter int WINDOW_DEPTH = pks_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [4:0]                   cfg_wr_data,
  input  logic [1:0]                   in_action,
  input  logic [5:0]                   in_tap_index,
  input  logic signed [15:0]           in_tap_value,
  input  logic signed [15:0]           in_sample_value,
  input  logic [31:0]                  in_sample_position,
  input  pks_pkg::pks_cmd_t            cmd,
  output pks_pkg::pks_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [pks_pkg::DENS_W-1:0] out_density,
  output logic [31:0]                  out_sample_number,
  output logic [31:0]                  out_result_position,
  output logic [1:0]                   out_status,
  output logic                         out_last_of_run
);
  import pks_pkg::*;

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int TW    = $clog2(MAX_TAPS);
  localparam int HMAX  = (MAX_TAPS - 1) / 2;
  localparam int ACC_W = (33 + CW > DENS_W + 1) ? 33 + CW : DENS_W + 1;
  localparam logic signed [ACC_W-1:0] DMAX = ACC_W'({1'b0, {(DENS_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] DMIN = ~DMAX;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] b, input logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(b) + (AW+1)'(off);
    if (s >= (AW+1)'(WINDOW_DEPTH)) s = s - (AW+1)'(WINDOW_DEPTH);
    return s[AW-1:0];
  endfunction

  logic [4:0]          hw_r;
  logic [HW-1:0]       h;
  logic [1:0]          act_r;
  logic [5:0]          tidx_r;
  logic signed [15:0]  tval_r, sval_r;
  logic [31:0]         spos_r;
  logic [CW-1:0]       count_r, head_r, i_r;
  logic [AW-1:0]       base_r;
  logic [31:0]         num_r, prev_r, first_r, pd_r, numd_r, ev_pos_r, ev_num_r;
  logic                started_r, ev_v_r, lost_r;
  logic                s1_v_r, s2_v_r, s3_v_r, s2_in_r;
  logic signed [15:0]  s2_val_r, tap_q, val_q;
  logic [31:0]         pos_q;
  logic signed [31:0]  prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [15:0]         val_mem [WINDOW_DEPTH];
  logic [31:0]         pos_mem [WINDOW_DEPTH];
  logic signed [15:0]  kmem [MAX_TAPS];
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [CW-1:0]       rd_off, dsel, age_d;
  logic signed [32:0]  diff, tsum;
  logic                in_rng, tap_ok;
  logic [TW-1:0]       taddr;
  logic signed [DENS_W-1:0] dens_sat, res_dens, hold_dens_r;
  logic [31:0]         res_num, res_pos, hold_num_r, hold_pos_r;
  logic [1:0]          res_st, hold_st_r;
  logic                hold_v_r, out_v_r;

  always_comb begin
    if (hw_r == 5'd0) h = HW'(1);
    else if (HW'(hw_r) > HW'(HMAX)) h = HW'(HMAX);
    else h = HW'(hw_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hw_r <= 5'd1;
    else if (cfg_wr_en) hw_r <= cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= in_action;
      tidx_r <= in_tap_index;
      tval_r <= in_tap_value;
      sval_r <= in_sample_value;
      spos_r <= in_sample_position;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD:  rd_off = head_r;
      RD_BASE:  rd_off = '0;
      RD_ISSUE: rd_off = i_r;
      default:  rd_off = '0;
    endcase
    rd_addr = wrap(base_r, rd_off);
    wr_addr = wrap(base_r, count_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      val_mem[wr_addr] <= sval_r;
      pos_mem[wr_addr] <= spos_r;
    end
    if (cmd.rd_en) begin
      val_q <= val_mem[rd_addr];
      pos_q <= pos_mem[rd_addr];
    end
  end

  assign tap_ok = {1'b0, tidx_r} < 7'(MAX_TAPS);
  assign diff   = $signed({1'b0, pos_q}) - $signed({1'b0, pd_r});
  assign in_rng = (diff > -$signed(33'(h))) && (diff < $signed(33'(h)));
  assign tsum   = $signed(33'(h)) + diff;
  assign taddr  = tsum[TW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.tap_wr && tap_ok) kmem[TW'(tidx_r)] <= tval_r;
    tap_q    <= kmem[taddr];
    s2_in_r  <= in_rng;
    s2_val_r <= val_q;
    prod_r   <= s2_in_r ? tap_q * s2_val_r : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.iss;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_pd) acc_r <= '0;
    else if (s3_v_r) acc_r <= acc_r + ACC_W'(prod_r);
  end

  assign dsel  = cmd.forced ? '0 : head_r;
  assign age_d = count_r - dsel;

  always_ff @(posedge clk) begin
    if (cmd.ld_pd) begin
      pd_r   <= pos_q;
      numd_r <= num_r - 32'(count_r) + 32'(dsel);
      lost_r <= ev_v_r && ((num_r - ev_num_r) <= 32'(age_d)) &&
                ((33'(ev_pos_r) + 33'(h)) > 33'(pos_q));
    end
    if (cmd.set_first) first_r <= (head_r < count_r) ? pos_q : spos_r;
    if (cmd.evict_rec) begin
      ev_pos_r <= pos_q;
      ev_num_r <= num_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      head_r    <= '0;
      base_r    <= '0;
      num_r     <= '0;
      prev_r    <= '0;
      started_r <= 1'b0;
      ev_v_r    <= 1'b0;
      i_r       <= '0;
    end else begin
      if (cmd.clear) begin
        count_r   <= '0;
        head_r    <= '0;
        base_r    <= '0;
        num_r     <= '0;
        prev_r    <= '0;
        started_r <= 1'b0;
        ev_v_r    <= 1'b0;
      end else begin
        if (cmd.drop) begin
          base_r  <= wrap(base_r, CW'(1));
          count_r <= count_r - CW'(1);
          if (head_r != '0) head_r <= head_r - CW'(1);
        end
        if (cmd.head_inc) head_r <= head_r + CW'(1);
        if (cmd.evict_rec) ev_v_r <= 1'b1;
        if (cmd.insert) begin
          count_r   <= count_r + CW'(1);
          num_r     <= num_r + 32'd1;
          prev_r    <= spos_r;
          started_r <= 1'b1;
        end
      end
      if (cmd.ld_pd) i_r <= '0;
      else if (cmd.iss) i_r <= i_r + CW'(1);
    end
  end

  always_comb begin
    if (acc_r > DMAX) dens_sat = DMAX[DENS_W-1:0];
    else if (acc_r < DMIN) dens_sat = DMIN[DENS_W-1:0];
    else dens_sat = acc_r[DENS_W-1:0];
    if (cmd.res_unsorted) begin
      res_dens = '0;
      res_num  = num_r;
      res_pos  = spos_r;
      res_st   = ST_UNSORTED;
    end else begin
      res_dens = dens_sat;
      res_num  = numd_r;
      res_pos  = pd_r;
      res_st   = (cmd.forced || lost_r) ? ST_OVERFLOW : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      hold_dens_r <= res_dens;
      hold_num_r  <= res_num;
      hold_pos_r  <= res_pos;
      hold_st_r   <= res_st;
    end
    if ((cmd.res_load && hold_v_r) || cmd.finish) begin
      out_density         <= hold_dens_r;
      out_sample_number   <= hold_num_r;
      out_result_position <= hold_pos_r;
      out_status          <= hold_st_r;
      out_last_of_run     <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.res_load) hold_v_r <= 1'b1;
      else if (cmd.finish) hold_v_r <= 1'b0;
      if ((cmd.res_load && hold_v_r) || cmd.finish) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
  end

  assign out_valid = out_v_r;

  always_comb begin
    sts.act        = act_r;
    sts.head_lt    = head_r < count_r;
    sts.head_cond  = (33'(pos_q) + 33'(h)) <= 33'(spos_r);
    sts.drop_cond  = (head_r != '0) && ((33'(pos_q) + 33'(h)) <= 33'(first_r));
    sts.full       = count_r >= CW'(WINDOW_DEPTH);
    sts.head_zero  = head_r == '0;
    sts.unsorted   = started_r && (spos_r < prev_r);
    sts.issue_done = i_r == count_r;
    sts.pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r;
    sts.out_free   = !out_v_r || !out_stall;
    sts.hold_v     = hold_v_r;
  end

`ifndef SYNTHESIS
  a_head_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= count_r) else $error("pending head beyond window count");
  a_count_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WINDOW_DEPTH)) else $error("window count beyond depth");
  a_finish_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !hold_v_r && out_v_r) else $error("final word not pushed");
  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> $past(s2_v_r)) else $error("mac pipeline out of order");
`endif

endmodule

// File: sv/pks_ctrl.sv
// controller state machine sequencing retire, drop, eviction, weighing and output
module pks_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pks_pkg::pks_sts_t sts,
  output pks_pkg::pks_cmd_t cmd
);
  import pks_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_URES = 4'd2;
  localparam logic [3:0] S_HRD  = 4'd3;
  localparam logic [3:0] S_HCHK = 4'd4;
  localparam logic [3:0] S_DRD  = 4'd5;
  localparam logic [3:0] S_DCHK = 4'd6;
  localparam logic [3:0] S_ERD  = 4'd7;
  localparam logic [3:0] S_EPD  = 4'd8;
  localparam logic [3:0] S_EISS = 4'd9;
  localparam logic [3:0] S_EDRN = 4'd10;
  localparam logic [3:0] S_ERES = 4'd11;
  localparam logic [3:0] S_INS  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       forced_r, forced_nxt;
  logic       flush;

  assign flush    = sts.act == ACT_FLUSH;
  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt  = state_r;
    forced_nxt = forced_r;
    cmd        = '0;
    cmd.forced = forced_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.act)
          ACT_LOAD: begin
            cmd.tap_wr = 1'b1;
            state_nxt  = S_IDLE;
          end
          ACT_SAMPLE: state_nxt = sts.unsorted ? S_URES : S_HRD;
          ACT_FLUSH:  state_nxt = S_HRD;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_URES: begin
        if (sts.out_free) begin
          cmd.res_load     = 1'b1;
          cmd.res_unsorted = 1'b1;
          state_nxt        = S_FIN;
        end
      end
      S_HRD: begin
        if (sts.head_lt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_nxt  = S_HCHK;
        end else if (flush) begin
          cmd.clear = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.set_first = 1'b1;
          state_nxt     = S_DRD;
        end
      end
      S_HCHK: begin
        if (flush || sts.head_cond) begin
          forced_nxt = 1'b0;
          state_nxt  = S_ERD;
        end else begin
          cmd.set_first = 1'b1;
          state_nxt     = S_DRD;
        end
      end
      S_DRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BASE;
        state_nxt  = S_DCHK;
      end
      S_DCHK: begin
        if (sts.drop_cond) begin
          cmd.drop  = 1'b1;
          state_nxt = S_DRD;
        end else if (sts.full) begin
          cmd.evict_rec = 1'b1;
          if (sts.head_zero) begin
            forced_nxt = 1'b1;
            state_nxt  = S_ERD;
          end else begin
            cmd.drop  = 1'b1;
            state_nxt = S_INS;
          end
        end else begin
          state_nxt = S_INS;
        end
      end
      S_ERD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = forced_r ? RD_BASE : RD_HEAD;
        state_nxt  = S_EPD;
      end
      S_EPD: begin
        cmd.ld_pd = 1'b1;
        state_nxt = S_EISS;
      end
      S_EISS: begin
        if (!sts.issue_done) begin
          cmd.iss    = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ISSUE;
        end else begin
          state_nxt = S_EDRN;
        end
      end
      S_EDRN: begin
        if (sts.pipe_empty) state_nxt = S_ERES;
      end
      S_ERES: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          if (forced_r) begin
            cmd.drop  = 1'b1;
            state_nxt = S_INS;
          end else begin
            cmd.head_inc = 1'b1;
            state_nxt    = S_HRD;
          end
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!sts.hold_v) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      forced_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      forced_r <= forced_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_DISP) else $error("accepted word not decoded");
  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.res_load && cmd.finish)) else $error("result load and finish together");
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_load || cmd.finish) |-> sts.out_free) else $error("push into busy output");
`endif

endmodule

// File: sv/positional_kernel_smoother_top.sv
// positional kernel smoother: top level joining controller and datapath
//
// input words carry an action: load a kernel tap, a sample, or a flush.
// taps are loaded first; samples then arrive in nondecreasing position.
// each result word gives density, sample number, position, status and a
// last_of_run flag on the final word caused by one input word.
// cfg_wr_en with cfg_wr_data sets half_width; write only while idle.
// one input word is taken at a time; in_stall is low only when idle.
// each result weighs the whole window, read through the single read port
// of the window memory, which feeds one multiplier.
// a flush emits every pending result, then clears the series.
// results pass through a hold register and an output register; out_stall
// holds the output word, and a finished result waits in the block until
// the output register is free or being taken.
// reset (rst_n low, synchronous) clears the window, counters and output;
// kernel taps and window contents stay undefined until written.
module positional_kernel_smoother_top #(
  parameter int MAX_TAPS     = pks_pkg::MAX_TAPS_DEF,
  parameter int WINDOW_DEPTH = pks_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [4:0]                        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [5:0]                        in_tap_index,
  input  logic signed [15:0]                in_tap_value,
  input  logic signed [15:0]                in_sample_value,
  input  logic [31:0]                       in_sample_position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pks_pkg::DENS_W-1:0] out_density,
  output logic [31:0]                       out_sample_number,
  output logic [31:0]                       out_result_position,
  output logic [1:0]                        out_status,
  output logic                              out_last_of_run
);
  import pks_pkg::*;

  pks_cmd_t cmd;
  pks_sts_t sts;

  pks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pks_datapath #(
    .MAX_TAPS     (MAX_TAPS),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_action           (in_action),
    .in_tap_index        (in_tap_index),
    .in_tap_value        (in_tap_value),
    .in_sample_value     (in_sample_value),
    .in_sample_position  (in_sample_position),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_density         (out_density),
    .out_sample_number   (out_sample_number),
    .out_result_position (out_result_position),
    .out_status          (out_status),
    .out_last_of_run     (out_last_of_run)
  );

endmodule
